### hw/rtl/okvt_pkg.sv
// shared types and constants for the ordered key-value table
// no dependencies; imported by the table core, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned POS_W      = 6;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_READ   = 3'd5
  } okvt_op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } okvt_status_e;

  // sequencer states of the table core
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SHIFT,
    S_RESULT
  } okvt_state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]     req_type;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic [POS_W-1:0]      req_position;
  } okvt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [KEY_BITS-1:0]   found_key;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_W-1:0]      entry_count;
  } okvt_rsp_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } okvt_entry_t;

endpackage

`default_nettype wire

### hw/rtl/okvt_core.sv
// table core: entry memory plus the sequencer for search, update, read and erase shift
// depends on okvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module okvt_core
  import okvt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire okvt_req_t req_i,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output okvt_rsp_t      rsp_o
);

  // entry memory, one write and one registered read per cycle
  okvt_entry_t mem [ENTRIES];
  okvt_entry_t rdata_q;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  okvt_entry_t mem_wdata;
  logic        mem_re;
  logic [IDX_W-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  okvt_state_e state_q, state_d;
  okvt_req_t   req_q, req_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;     // next address to read
  logic             pend_q, pend_d;     // a read is in flight
  logic [IDX_W-1:0] idx_q, idx_d;       // address of the read in flight / shift target
  okvt_status_e     status_q, status_d;
  logic [KEY_BITS-1:0]   fkey_q, fkey_d;
  logic [VALUE_BITS-1:0] fval_q, fval_d;

  logic found;
  logic miss;
  okvt_entry_t req_entry;

  assign req_entry = '{key: req_q.req_key, value: req_q.req_value};
  assign found = pend_q && (rdata_q.key == req_q.req_key);
  assign miss  = !pend_q && (scan_q >= count_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    scan_q   <= scan_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    fkey_q   <= fkey_d;
    fval_q   <= fval_d;
  end

  // next state, memory control and result
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    count_d   = count_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    idx_d     = idx_q;
    status_d  = status_q;
    fkey_d    = fkey_q;
    fval_d    = fval_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = req_entry;
    mem_re    = 1'b0;
    mem_raddr = scan_q[IDX_W-1:0];
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d    = req_i;
          status_d = ST_OK;
          fkey_d   = '0;
          fval_d   = '0;
          scan_d   = '0;
          pend_d   = 1'b0;
          case (req_i.req_type)
            OP_READ: begin
              if (CNT_W'(req_i.req_position) < count_q) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(req_i.req_position);
                state_d   = S_READ;
              end else begin
                status_d = ST_RANGE;
                state_d  = S_RESULT;
              end
            end
            OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP: begin
              state_d = S_SEARCH;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end

      // linear key search, one read issued per cycle, compared in the following cycle
      S_SEARCH: begin
        if (found || miss) begin
          state_d = S_RESULT;
          pend_d  = 1'b0;
          case (req_q.req_type)
            OP_INSERT, OP_UPSERT: begin
              if (found && req_q.req_type == OP_UPSERT) begin
                mem_we = 1'b1;
              end else if (found) begin
                status_d = ST_PRESENT;
              end else if (count_q >= CNT_W'(ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                count_d   = count_q + CNT_W'(1);
              end
            end
            OP_UPDATE: begin
              if (found) begin
                mem_we = 1'b1;
              end else begin
                status_d = ST_ABSENT;
              end
            end
            OP_ERASE: begin
              if (found) begin
                scan_d  = CNT_W'(idx_q) + CNT_W'(1);
                state_d = S_SHIFT;
              end else begin
                status_d = ST_ABSENT;
              end
            end
            OP_LOOKUP: begin
              if (found) begin
                fkey_d = rdata_q.key;
                fval_d = rdata_q.value;
              end else begin
                status_d = ST_ABSENT;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end else if (scan_q < count_q) begin
          mem_re = 1'b1;
          idx_d  = scan_q[IDX_W-1:0];
          scan_d = scan_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      // read position data returns
      S_READ: begin
        fkey_d  = rdata_q.key;
        fval_d  = rdata_q.value;
        state_d = S_RESULT;
      end

      // close the gap: read entry j+1, write it to j on the next cycle
      S_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = rdata_q;
          idx_d     = idx_q + IDX_W'(1);
        end
        if (scan_q < count_q) begin
          mem_re = 1'b1;
          scan_d = scan_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o = '{status:      status_q,
                   found_key:   fkey_q,
                   found_value: fval_q,
                   entry_count: count_q};

endmodule

`default_nettype wire

### hw/rtl/ordered_key_value_table_top.sv
// insert, update, lookup and erase take longer with more stored entries; one request in flight,
// set by the single read port of the entry memory used for the key search and the erase shift
// a finished result waits in the output register while the next request is taken
// reset: asynchronous, active low; the table comes up empty, entries undefined until written
// depends on okvt_pkg and okvt_core
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_value_table_top
  import okvt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire okvt_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output okvt_rsp_t      out_rsp_o
);

  logic      core_ready;
  logic      core_rsp_valid;
  logic      core_rsp_ready;
  okvt_rsp_t core_rsp;
  logic      out_valid_q, out_valid_d;
  okvt_rsp_t out_rsp_q;

  okvt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (core_ready),
    .req_i       (in_req_i),
    .rsp_valid_o (core_rsp_valid),
    .rsp_ready_i (core_rsp_ready),
    .rsp_o       (core_rsp)
  );

  assign in_stall_o = !core_ready;

  // output register
  assign core_rsp_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_rsp_valid && core_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_rsp_valid && core_rsp_ready) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

### hw/rtl/okvt_checker.sv
// port-level checks for the ordered key-value table, bound to the top level
// depends on okvt_pkg and ordered_key_value_table_top
`timescale 1ns / 1ps
`default_nettype none

module okvt_checker
  import okvt_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire okvt_req_t in_req_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire okvt_rsp_t out_rsp_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // one request at a time: an accepted request blocks the next cycle
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in work");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.entry_count <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  // failing requests report no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_ABSENT || out_rsp_o.status == ST_PRESENT ||
                    out_rsp_o.status == ST_FULL || out_rsp_o.status == ST_RANGE)
    |-> out_rsp_o.found_key == '0 && out_rsp_o.found_value == '0)
    else $error("failed request returned entry data");

endmodule

bind ordered_key_value_table_top okvt_checker u_okvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
